[rtl/ncd_pkg.sv]
// Shared types and constants for the negative cycle detector.
`timescale 1ns / 1ps

package ncd_pkg;

	// Field widths of the input and configuration transactions.
	localparam int VTX_W    = 10;
	localparam int WEIGHT_W = 16;
	localparam int VC_W     = 10;

	// Distance store spans every vertex code that the endpoint fields can carry.
	localparam int NUM_VERTICES = 1 << VTX_W;

	// Starting distance of every vertex but the source vertex.
	localparam longint INIT_DISTANCE = 64'sd1000000010;

	// The source vertex of every solve.
	localparam logic [VTX_W-1:0] SOURCE_VERTEX = VTX_W'(1);

	// Operation codes of the input channel.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SOLVE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic edge_we;   // store an edge from the input fields
		logic edge_re;   // fetch the edge at the current edge index
		logic clr_en;    // write the starting distance of the clear index
		logic dist_re;   // read source and destination distances
		logic rev;       // relax the reverse direction of the fetched edge
		logic apply;     // lower the destination distance if the edge relaxes
	} ncd_cmd_t;

endpackage

[rtl/ncd_ram.sv]
// Generic single write port, single registered read port RAM.
`timescale 1ns / 1ps

module ncd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/ncd_datapath.sv]
// Edge store, mirrored distance stores and the relaxation add and compare.
`timescale 1ns / 1ps

module ncd_datapath
	import ncd_pkg::*;
#(
	parameter int MAX_EDGES = 4096,
	parameter int DIST_W    = 40,
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
	input  logic                       clk,
	input  ncd_cmd_t                   cmd,
	input  logic [AW-1:0]              edge_addr,
	input  logic [VTX_W-1:0]           clr_addr,
	input  logic [VTX_W-1:0]           from_vertex,
	input  logic [VTX_W-1:0]           to_vertex,
	input  logic signed [WEIGHT_W-1:0] weight,
	output logic                       relax
);

	localparam int EDGE_W = 2 * VTX_W + WEIGHT_W;

	logic [EDGE_W-1:0]          edge_rd;
	logic [VTX_W-1:0]           edge_a;
	logic [VTX_W-1:0]           edge_b;
	logic signed [DIST_W-1:0]   c_ext;
	logic signed [DIST_W-1:0]   w_ext;
	logic [VTX_W-1:0]           src;
	logic [VTX_W-1:0]           dst;
	logic signed [DIST_W-1:0]   dist_src;
	logic signed [DIST_W-1:0]   dist_dst;
	logic signed [DIST_W-1:0]   cand;
	logic                       dist_we;
	logic [VTX_W-1:0]           dist_waddr;
	logic [DIST_W-1:0]          dist_wdata;

	ncd_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk     (clk),
		.wr_en   (cmd.edge_we),
		.wr_addr (edge_addr),
		.wr_data ({from_vertex, to_vertex, weight}),
		.rd_en   (cmd.edge_re),
		.rd_addr (edge_addr),
		.rd_data (edge_rd)
	);

	assign edge_a = edge_rd[EDGE_W-1 -: VTX_W];
	assign edge_b = edge_rd[WEIGHT_W +: VTX_W];
	assign c_ext  = DIST_W'(signed'(edge_rd[WEIGHT_W-1:0]));
	assign w_ext  = cmd.rev ? -c_ext : c_ext;
	assign src    = cmd.rev ? edge_b : edge_a;
	assign dst    = cmd.rev ? edge_a : edge_b;

	// Two copies of the distances give two reads a cycle; every write goes to both.
	ncd_ram #(.WIDTH(DIST_W), .DEPTH(NUM_VERTICES)) u_dist_src_ram (
		.clk     (clk),
		.wr_en   (dist_we),
		.wr_addr (dist_waddr),
		.wr_data (dist_wdata),
		.rd_en   (cmd.dist_re),
		.rd_addr (src),
		.rd_data (dist_src)
	);

	ncd_ram #(.WIDTH(DIST_W), .DEPTH(NUM_VERTICES)) u_dist_dst_ram (
		.clk     (clk),
		.wr_en   (dist_we),
		.wr_addr (dist_waddr),
		.wr_data (dist_wdata),
		.rd_en   (cmd.dist_re),
		.rd_addr (dst),
		.rd_data (dist_dst)
	);

	assign cand  = dist_src + w_ext;
	assign relax = (cand < dist_dst);

	always_comb begin
		if (cmd.clr_en) begin
			dist_we    = 1'b1;
			dist_waddr = clr_addr;
			dist_wdata = (clr_addr == SOURCE_VERTEX) ? '0 : DIST_W'(INIT_DISTANCE);
		end else begin
			dist_we    = cmd.apply && relax;
			dist_waddr = dst;
			dist_wdata = cand;
		end
	end

endmodule

[rtl/ncd_ctrl.sv]
// Controller: handshakes, configuration register, edge count and solve sequencing.
`timescale 1ns / 1ps

module ncd_ctrl
	import ncd_pkg::*;
#(
	parameter int MAX_EDGES = 4096,
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int CW = $clog2(MAX_EDGES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             operation,
	input  logic             cfg_valid,
	input  logic [VC_W-1:0]  cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             negative_cycle,
	output ncd_cmd_t         cmd,
	output logic [AW-1:0]    edge_addr,
	output logic [VTX_W-1:0] clr_addr,
	input  logic             relax
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_F_RD  = 3'd3;
	localparam logic [2:0] ST_F_CMP = 3'd4;
	localparam logic [2:0] ST_R_RD  = 3'd5;
	localparam logic [2:0] ST_R_CMP = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]       state_q;
	logic [VC_W-1:0]  vertex_count_q;
	logic [CW-1:0]    edge_total_q;
	logic [AW-1:0]    edge_idx_q;
	logic [VC_W-1:0]  pass_q;
	logic [VTX_W-1:0] clr_q;
	logic             check_q;
	logic             found_q;
	logic             out_valid_q;
	logic             negative_cycle_q;

	logic             in_acc;
	logic             full;
	logic             last_edge;
	logic [VC_W-1:0]  passes;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign full      = (edge_total_q == CW'(MAX_EDGES));
	assign last_edge = ((CW'(edge_idx_q) + CW'(1)) == edge_total_q);
	assign passes    = (vertex_count_q == '0) ? '0 : vertex_count_q - VC_W'(1);

	assign edge_addr = (state_q == ST_IDLE) ? edge_total_q[AW-1:0] : edge_idx_q;
	assign clr_addr  = clr_q;

	always_comb begin
		cmd         = '0;
		cmd.edge_we = in_acc && (operation == OP_ADD) && !full;
		cmd.edge_re = (state_q == ST_FETCH);
		cmd.clr_en  = (state_q == ST_CLEAR);
		cmd.dist_re = (state_q == ST_F_RD) || (state_q == ST_R_RD);
		cmd.rev     = (state_q == ST_R_RD) || (state_q == ST_R_CMP);
		cmd.apply   = !check_q && ((state_q == ST_F_CMP) || (state_q == ST_R_CMP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_W'(1);
		end else if (cfg_valid) begin
			vertex_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			edge_total_q     <= '0;
			edge_idx_q       <= '0;
			pass_q           <= '0;
			clr_q            <= '0;
			check_q          <= 1'b0;
			found_q          <= 1'b0;
			out_valid_q      <= 1'b0;
			negative_cycle_q <= 1'b0;
		end else begin
			// In the done state the verdict register is reloaded instead.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (operation == OP_SOLVE) begin
							found_q <= 1'b0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else if (!full) begin
							edge_total_q <= edge_total_q + CW'(1);
						end
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + VTX_W'(1);
					if (clr_q == VTX_W'(NUM_VERTICES - 1)) begin
						edge_idx_q <= '0;
						pass_q     <= '0;
						check_q    <= (passes == '0);
						state_q    <= (edge_total_q == '0) ? ST_DONE : ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_F_RD;
				end
				ST_F_RD: begin
					state_q <= ST_F_CMP;
				end
				ST_F_CMP: begin
					if (check_q && relax) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_R_RD;
					end
				end
				ST_R_RD: begin
					state_q <= ST_R_CMP;
				end
				ST_R_CMP: begin
					if (check_q && relax) begin
						found_q <= 1'b1;
						state_q <= ST_DONE;
					end else if (last_edge) begin
						edge_idx_q <= '0;
						if (check_q) begin
							state_q <= ST_DONE;
						end else begin
							pass_q <= pass_q + VC_W'(1);
							if ((pass_q + VC_W'(1)) == passes) begin
								check_q <= 1'b1;
							end
							state_q <= ST_FETCH;
						end
					end else begin
						edge_idx_q <= edge_idx_q + AW'(1);
						state_q    <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q      <= 1'b1;
						negative_cycle_q <= found_q;
						edge_total_q     <= '0;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign negative_cycle = negative_cycle_q;

endmodule

[rtl/negative_cycle_detector.sv]
// Top level of the Bellman-Ford negative cycle detector.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    operation, from_vertex, to_vertex, weight
// result    out        out_valid / out_ready  negative_cycle
// config    in         cfg_valid / cfg_ready  cfg_data (vertex_count)
//
// An add transaction leaves the block idle, so edges load at one per cycle while it is idle.
// A solve first clears all NUM_VERTICES (1024) entries of the distance store and then
// makes P passes over the E stored edges, where P is vertex_count, or one when it is
// zero (the relaxation passes plus the final check pass, which stops at the first edge
// that still relaxes). Each directed edge takes a distance read state and a compare and
// write state, and every edge first needs an edge store read state.
// Reset clears the edge count and sets vertex_count to one; the stores are not cleared.
// A finished verdict waits in the output register while new transactions are taken;
// a second verdict holds the block until the first has been taken.

module negative_cycle_detector
	import ncd_pkg::*;
#(
	parameter int MAX_EDGES = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       operation,
	input  logic [VTX_W-1:0]           from_vertex,
	input  logic [VTX_W-1:0]           to_vertex,
	input  logic signed [WEIGHT_W-1:0] weight,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       negative_cycle,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [VC_W-1:0]            cfg_data
);

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	// Largest distance magnitude: every pass may move a distance by the full weight
	// range along every directed edge. One more bit carries the sign.
	localparam longint MAX_MAG = INIT_DISTANCE +
		longint'(NUM_VERTICES - 1) * 2 * longint'(MAX_EDGES) * (longint'(1) << (WEIGHT_W - 1));
	localparam int DIST_W = $clog2(MAX_MAG + 1) + 1;

	ncd_cmd_t         cmd;
	logic [AW-1:0]    edge_addr;
	logic [VTX_W-1:0] clr_addr;
	logic             relax;

	// The configuration register may be written at any time the block is idle.
	assign cfg_ready = 1'b1;

	ncd_ctrl #(.MAX_EDGES(MAX_EDGES)) u_ncd_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.negative_cycle (negative_cycle),
		.cmd            (cmd),
		.edge_addr      (edge_addr),
		.clr_addr       (clr_addr),
		.relax          (relax)
	);

	ncd_datapath #(.MAX_EDGES(MAX_EDGES), .DIST_W(DIST_W)) u_ncd_datapath (
		.clk         (clk),
		.cmd         (cmd),
		.edge_addr   (edge_addr),
		.clr_addr    (clr_addr),
		.from_vertex (from_vertex),
		.to_vertex   (to_vertex),
		.weight      (weight),
		.relax       (relax)
	);

endmodule

[rtl/ncd_checker.sv]
// Port-level checker for the negative cycle detector and its bind statement.
`timescale 1ns / 1ps

module ncd_checker
	import ncd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic operation,
	input logic out_valid,
	input logic out_ready,
	input logic negative_cycle
);

	// A stalled verdict keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(negative_cycle))
		else $error("verdict changed or dropped while stalled");

	// An add transaction completes at once, so the next one can follow.
	a_add_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_ADD |=> in_ready)
		else $error("input not ready after an add transaction");

	// A solve transaction occupies the block.
	a_solve_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == OP_SOLVE |=> !in_ready)
		else $error("input ready directly after a solve transaction");

	// A verdict is loaded only at the end of a solve, while input is held off.
	a_verdict_after_solve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("verdict appeared outside a solve");

endmodule

bind negative_cycle_detector ncd_checker u_ncd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.operation      (operation),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.negative_cycle (negative_cycle)
);

[dv/negative_cycle_detector_test.sv]
// Self-checking testbench for the negative cycle detector top level.
`timescale 1ns / 1ps

module negative_cycle_detector_test;
	import ncd_pkg::*;

	// Depth of the block's edge store at its default size, and the largest random set.
	localparam int STORE_DEPTH    = 4096;
	localparam int SET_MAX        = 16;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int RANDOM_ITEMS   = 600;

	typedef struct {
		logic                       op;
		logic [VTX_W-1:0]           src;
		logic [VTX_W-1:0]           dst;
		logic signed [WEIGHT_W-1:0] wgt;
	} edge_item_t;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       in_valid       = 1'b0;
	logic                       in_ready;
	logic                       operation      = OP_ADD;
	logic [VTX_W-1:0]           from_vertex    = '0;
	logic [VTX_W-1:0]           to_vertex      = '0;
	logic signed [WEIGHT_W-1:0] weight         = '0;
	logic                       out_valid;
	logic                       out_ready      = 1'b0;
	logic                       negative_cycle;
	logic                       cfg_valid      = 1'b0;
	logic                       cfg_ready;
	logic [VC_W-1:0]            cfg_data       = '0;

	// Transactions waiting to be driven, and verdicts waiting to be seen.
	edge_item_t pending_items[$];
	edge_item_t drive_item;
	logic       expected_verdicts[$];

	// Our own copy of the block's state: the edge list, the register and the distances.
	logic [VTX_W-1:0] edge_from   [STORE_DEPTH];
	logic [VTX_W-1:0] edge_to     [STORE_DEPTH];
	longint           edge_weight [STORE_DEPTH];
	int               edge_count;
	logic [VC_W-1:0]  model_vertex_count;
	longint           distance    [NUM_VERTICES];

	int error_count;
	int quiet_cycles;
	int random_items;
	int sender_idle_pct;
	int receiver_stall_pct;

	negative_cycle_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.from_vertex   (from_vertex),
		.to_vertex     (to_vertex),
		.weight        (weight),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.negative_cycle(negative_cycle),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		error_count++;
	endtask

	// Tries one directed edge; lowers the destination distance when asked to.
	function automatic logic edge_relaxes(input logic [VTX_W-1:0] src,
			input logic [VTX_W-1:0] dst, input longint w, input logic apply);
		longint cand;
		cand = distance[src] + w;
		if (cand < distance[dst]) begin
			if (apply)
				distance[dst] = cand;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Bellman-Ford over the stored edges. Each edge is tried forwards and then
	// backwards with the negated weight, and unreached vertices are not skipped.
	function automatic logic solve_verdict();
		int passes;
		for (int v = 0; v < NUM_VERTICES; v++)
			distance[v] = INIT_DISTANCE;
		distance[SOURCE_VERTEX] = 0;
		// A vertex count of zero behaves as one: no relaxation pass at all.
		passes = (model_vertex_count == 0) ? 0 : int'(model_vertex_count) - 1;
		for (int p = 0; p < passes; p++) begin
			for (int k = 0; k < edge_count; k++) begin
				void'(edge_relaxes(edge_from[k], edge_to[k], edge_weight[k], 1'b1));
				void'(edge_relaxes(edge_to[k], edge_from[k], -edge_weight[k], 1'b1));
			end
		end
		// The checking pass only looks; an empty edge list gives no cycle.
		for (int k = 0; k < edge_count; k++) begin
			if (edge_relaxes(edge_from[k], edge_to[k], edge_weight[k], 1'b0) ||
					edge_relaxes(edge_to[k], edge_from[k], -edge_weight[k], 1'b0))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Applies one accepted input transaction to the model, using the held payload.
	task automatic record_transaction();
		if (operation == OP_ADD) begin
			// Once the store is full, further edges are dropped without trace.
			if (edge_count < STORE_DEPTH) begin
				edge_from[edge_count]   = from_vertex;
				edge_to[edge_count]     = to_vertex;
				edge_weight[edge_count] = longint'(weight);
				edge_count++;
			end
		end else begin
			expected_verdicts.insert(expected_verdicts.size(), solve_verdict());
			edge_count = 0;
		end
	endtask

	// Input driver. A new transaction is offered only when the slot is free, so valid
	// and the payload hold steady until the block takes them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				record_transaction();
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					drive_item = pending_items.pop_front();
					in_valid    <= 1'b1;
					operation   <= drive_item.op;
					from_vertex <= drive_item.src;
					to_vertex   <= drive_item.dst;
					weight      <= drive_item.wgt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor, with random back-pressure on the output channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0)
					report_mismatch("verdict arrived with none expected");
				else if (negative_cycle !== expected_verdicts[0]) begin
					report_mismatch($sformatf("negative_cycle is %b, expected %b",
						negative_cycle, expected_verdicts[0]));
					void'(expected_verdicts.pop_front());
				end else begin
					void'(expected_verdicts.pop_front());
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// The run is abandoned if no channel completes a transaction for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_add(input int a, input int b, input int w);
		edge_item_t item;
		item.op  = OP_ADD;
		item.src = a[VTX_W-1:0];
		item.dst = b[VTX_W-1:0];
		item.wgt = w[WEIGHT_W-1:0];
		pending_items.insert(pending_items.size(), item);
	endtask

	task automatic push_solve();
		edge_item_t item;
		item.op  = OP_SOLVE;
		item.src = VTX_W'($urandom_range(NUM_VERTICES - 1));
		item.dst = VTX_W'($urandom_range(NUM_VERTICES - 1));
		item.wgt = WEIGHT_W'($urandom_range(16'hFFFF));
		pending_items.insert(pending_items.size(), item);
	endtask

	// Holds off until the block has nothing left to do: every queued transaction is
	// taken and every verdict has come back. A trailing add may still be in flight,
	// so the task then idles before the caller touches the register.
	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_verdicts.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// Writes vertex_count; only called while the block is idle.
	task automatic write_vertex_count(input int value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value[VC_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_vertex_count = value[VC_W-1:0];
		@(negedge clk);
	endtask

	// One edge set followed by a solve. Most sets are consistent with a random vertex
	// potential, so only the chosen vertex count and a deliberate perturbation decide
	// the verdict; the rest are random weights or full-range noise.
	task automatic push_random_set();
		int kind;
		int pick;
		int size;
		int nv;
		int idx;
		int pot [12];
		int ea  [SET_MAX];
		int eb  [SET_MAX];
		int ew  [SET_MAX];
		if ($urandom_range(1)) begin
			wait_until_drained();
			pick = $urandom_range(99);
			if (pick < 5)
				write_vertex_count(1023);
			else if (pick < 10)
				write_vertex_count($urandom_range(1));
			else
				write_vertex_count($urandom_range(2, 12));
		end
		kind = $urandom_range(99);
		// The widest vertex count is slow, so it only ever sees a couple of edges.
		if (model_vertex_count == 1023)
			size = $urandom_range(2);
		else
			size = $urandom_range(SET_MAX);
		if (model_vertex_count >= 2 && model_vertex_count <= 12)
			nv = model_vertex_count;
		else
			nv = $urandom_range(2, 6);
		foreach (pot[i])
			pot[i] = int'($urandom_range(32000)) - 16000;
		for (int k = 0; k < size; k++) begin
			if (kind < 70 || kind >= 95) begin
				ea[k] = $urandom_range(nv - 1);
				eb[k] = $urandom_range(nv - 1);
				ew[k] = pot[eb[k]] - pot[ea[k]];
			end else if (kind < 85) begin
				ea[k] = $urandom_range(nv - 1);
				eb[k] = $urandom_range(nv - 1);
				ew[k] = int'($urandom_range(400)) - 200;
			end else begin
				ea[k] = $urandom_range(NUM_VERTICES - 1);
				eb[k] = $urandom_range(NUM_VERTICES - 1);
				ew[k] = int'($urandom_range(65535)) - 32768;
			end
		end
		// Knock one consistent edge off its potential to close a negative cycle.
		if (kind < 35 && size > 0) begin
			idx = $urandom_range(size - 1);
			ew[idx] += $urandom_range(1) ? int'($urandom_range(1, 50)) :
				-int'($urandom_range(1, 50));
		end
		for (int k = 0; k < size; k++)
			push_add(ea[k], eb[k], ew[k]);
		push_solve();
		random_items += size + 1;
	endtask

	initial begin
		edge_count         = 0;
		model_vertex_count = 1;
		error_count        = 0;
		random_items       = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Empty edge list with the vertex count left at its reset value of one.
		push_solve();
		wait_until_drained();

		// Vertex count zero: no relaxation, only the final check. The endpoints and
		// the weight sit at the ends of their ranges.
		write_vertex_count(0);
		push_add(0, NUM_VERTICES - 1, -32768);
		push_add(NUM_VERTICES - 1, 0, 32767);
		push_solve();
		wait_until_drained();

		// Widest vertex count: a consistent triangle, then the same with one short edge.
		write_vertex_count(1023);
		push_add(1, 2, 5);
		push_add(2, 3, 5);
		push_add(1, 3, 10);
		push_solve();
		push_add(1, 2, 5);
		push_add(2, 3, 5);
		push_add(1, 3, 3);
		push_solve();
		wait_until_drained();

		// A self loop, then the weight extremes on a chain from the source vertex.
		write_vertex_count(4);
		push_add(2, 2, -1);
		push_add(1, 2, 0);
		push_add(512, 1, 1);
		push_solve();
		push_add(1, 2, 32767);
		push_add(2, 3, -32768);
		push_solve();
		wait_until_drained();

		// Random sets, once for each idling pattern of the two sides.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
				default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
			endcase
			while (random_items < (phase + 1) * RANDOM_ITEMS / 4)
				push_random_set();
			wait_until_drained();
		end

		wait_until_drained();
		repeat (20) @(negedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch("verdicts still outstanding at the end");
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
